// File: rtl/ppms_pkg.sv
// Package for the pick-and-place motion sequencer: word types, codes and register map.
`timescale 1ns / 1ps

package ppms_pkg;

  // Field widths
  localparam int unsigned PosW     = 32;
  localparam int unsigned TimeW    = 24;
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned PhaseW   = 4;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  // Counter ceiling and timeout after reset
  localparam logic [TimeW-1:0] WaitMax        = {TimeW{1'b1}};
  localparam logic [TimeW-1:0] TimeoutDefault = TimeW'(3000);

  // Register indexes
  localparam logic [CfgAddrW-1:0] REG_SAFE_Z       = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_PICK_Z       = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_PLACE_Z      = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_PICK_X       = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_PICK_Y       = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_PLACE_X      = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_PLACE_Y      = 3'd6;
  localparam logic [CfgAddrW-1:0] REG_MOVE_TIMEOUT = 3'd7;

  // Commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_POLL  = 1'b1;

  // Verdicts
  localparam logic [1:0] VERDICT_POLL  = 2'd0;
  localparam logic [1:0] VERDICT_DONE  = 2'd1;
  localparam logic [1:0] VERDICT_ERROR = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_NO_ACT   = 2'd1;
  localparam logic [1:0] ERR_REFUSED  = 2'd2;
  localparam logic [1:0] ERR_TIMEOUT  = 2'd3;

  // Move kinds
  localparam logic KIND_Z  = 1'b0;
  localparam logic KIND_XY = 1'b1;

  // Phase codes in sequence order
  localparam logic [PhaseW-1:0] PH_RAISE_START  = 4'd0;
  localparam logic [PhaseW-1:0] PH_TO_PICK_XY   = 4'd1;
  localparam logic [PhaseW-1:0] PH_LOWER_PICK   = 4'd2;
  localparam logic [PhaseW-1:0] PH_CLAMP_WAIT   = 4'd3;
  localparam logic [PhaseW-1:0] PH_RAISE_PICK   = 4'd4;
  localparam logic [PhaseW-1:0] PH_TO_PLACE_XY  = 4'd5;
  localparam logic [PhaseW-1:0] PH_LOWER_PLACE  = 4'd6;
  localparam logic [PhaseW-1:0] PH_RELEASE_WAIT = 4'd7;
  localparam logic [PhaseW-1:0] PH_RAISE_END    = 4'd8;
  localparam logic [PhaseW-1:0] PH_FINAL        = 4'd9;

  // Input word
  typedef struct packed {
    logic                command;
    logic                actuator_present;
    logic                at_target;
    logic                cmd_accepted;
    logic [ElapsedW-1:0] elapsed_ms;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [1:0]               verdict;
    logic [1:0]               error_code;
    logic [PhaseW-1:0]        phase;
    logic                     cmd_valid;
    logic                     cmd_kind;
    logic signed [PosW-1:0]   target_x;
    logic signed [PosW-1:0]   target_y;
    logic signed [PosW-1:0]   target_z;
  } out_word_t;

endpackage

// File: rtl/pick_place_motion_sequencer.sv
// Top level of the pick-and-place motion sequencer: phase logic, wait counter, result register.
`timescale 1ns / 1ps

// Channel  Direction  Signals                      Word
// in       input      in_valid, in_ready, in_data   ppms_pkg::in_word_t
// out      output     out_valid, out_ready, out_data ppms_pkg::out_word_t
// cfg      input      cfg_we, cfg_addr, cfg_wdata   one register per write
//
// The phase decision and the saturating add to the wait counter sit between
// the phase/counter registers and the result register.
// A word is accepted while the result register is empty or being drained, so
// a word can enter in every cycle; a stalled out_ready holds one result and
// then holds in_ready low. Reset clears phase, counter and output valid and
// loads the register defaults.

module pick_place_motion_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ppms_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ppms_pkg::out_word_t                out_data,
  input  logic                               cfg_we,
  input  logic [ppms_pkg::CfgAddrW-1:0]      cfg_addr,
  input  logic [ppms_pkg::CfgDataW-1:0]      cfg_wdata
);

  // Configuration registers
  logic signed [ppms_pkg::PosW-1:0] safe_z_r, pick_z_r, place_z_r;
  logic signed [ppms_pkg::PosW-1:0] pick_x_r, pick_y_r, place_x_r, place_y_r;
  logic [ppms_pkg::TimeW-1:0]       move_timeout_r;

  // Sequencer state
  logic [ppms_pkg::PhaseW-1:0] phase_r, phase_nxt;
  logic [ppms_pkg::TimeW-1:0]  wait_r, wait_nxt;

  // Result register
  logic                 out_valid_r;
  ppms_pkg::out_word_t  out_data_r, out_data_nxt;

  logic                        accept;
  logic                        waits;
  logic                        issues;
  logic [ppms_pkg::TimeW:0]    wait_sum;
  logic [ppms_pkg::TimeW-1:0]  wait_sat;
  logic                        kind_xy;
  logic signed [ppms_pkg::PosW-1:0] tx, ty, tz;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      safe_z_r       <= '0;
      pick_z_r       <= '0;
      place_z_r      <= '0;
      pick_x_r       <= '0;
      pick_y_r       <= '0;
      place_x_r      <= '0;
      place_y_r      <= '0;
      move_timeout_r <= ppms_pkg::TimeoutDefault;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ppms_pkg::REG_SAFE_Z:       safe_z_r       <= cfg_wdata;
        ppms_pkg::REG_PICK_Z:       pick_z_r       <= cfg_wdata;
        ppms_pkg::REG_PLACE_Z:      place_z_r      <= cfg_wdata;
        ppms_pkg::REG_PICK_X:       pick_x_r       <= cfg_wdata;
        ppms_pkg::REG_PICK_Y:       pick_y_r       <= cfg_wdata;
        ppms_pkg::REG_PLACE_X:      place_x_r      <= cfg_wdata;
        ppms_pkg::REG_PLACE_Y:      place_y_r      <= cfg_wdata;
        ppms_pkg::REG_MOVE_TIMEOUT: move_timeout_r <= cfg_wdata[ppms_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  // Classify the phase and add elapsed time with saturation
  always_comb begin
    waits = !(phase_r == ppms_pkg::PH_RAISE_START || phase_r == ppms_pkg::PH_RAISE_PICK ||
              phase_r == ppms_pkg::PH_RAISE_END);
    issues = !(phase_r == ppms_pkg::PH_CLAMP_WAIT || phase_r == ppms_pkg::PH_RELEASE_WAIT ||
               phase_r == ppms_pkg::PH_FINAL);
    wait_sum = {1'b0, wait_r} + (ppms_pkg::TimeW + 1)'(in_data.elapsed_ms);
    wait_sat = wait_sum[ppms_pkg::TimeW] ? ppms_pkg::WaitMax
                                         : wait_sum[ppms_pkg::TimeW-1:0];
  end

  // Pick the move target of the phase
  always_comb begin
    kind_xy = ppms_pkg::KIND_Z;
    tx      = '0;
    ty      = '0;
    tz      = '0;
    unique case (phase_r) inside
      ppms_pkg::PH_RAISE_START, ppms_pkg::PH_RAISE_PICK, ppms_pkg::PH_RAISE_END: begin
        tz = safe_z_r;
      end
      ppms_pkg::PH_TO_PICK_XY: begin
        kind_xy = ppms_pkg::KIND_XY;
        tx      = pick_x_r;
        ty      = pick_y_r;
      end
      ppms_pkg::PH_LOWER_PICK: tz = pick_z_r;
      ppms_pkg::PH_TO_PLACE_XY: begin
        kind_xy = ppms_pkg::KIND_XY;
        tx      = place_x_r;
        ty      = place_y_r;
      end
      default: tz = place_z_r;
    endcase
  end

  // Decide the step: next phase, next counter and the result word
  always_comb begin
    phase_nxt    = phase_r;
    wait_nxt     = wait_r;
    out_data_nxt = '0;
    out_data_nxt.phase = phase_r;
    if (in_data.command == ppms_pkg::CMD_START) begin
      // restart from the first phase
      phase_nxt          = ppms_pkg::PH_RAISE_START;
      wait_nxt           = '0;
      out_data_nxt.phase = ppms_pkg::PH_RAISE_START;
    end else if (phase_r > ppms_pkg::PH_FINAL) begin
      out_data_nxt.verdict    = ppms_pkg::VERDICT_ERROR;
      out_data_nxt.error_code = ppms_pkg::ERR_REFUSED;
    end else begin
      if (waits) begin
        wait_nxt = wait_sat;
      end
      if (!in_data.actuator_present) begin
        out_data_nxt.verdict    = ppms_pkg::VERDICT_ERROR;
        out_data_nxt.error_code = ppms_pkg::ERR_NO_ACT;
      end else if (waits && !in_data.at_target) begin
        // still waiting: time out once the counter reaches the limit
        if (wait_sat >= move_timeout_r) begin
          out_data_nxt.verdict    = ppms_pkg::VERDICT_ERROR;
          out_data_nxt.error_code = ppms_pkg::ERR_TIMEOUT;
        end
      end else if (!issues) begin
        if (phase_r == ppms_pkg::PH_FINAL) begin
          out_data_nxt.verdict = ppms_pkg::VERDICT_DONE;
        end else begin
          phase_nxt          = phase_r + 1'b1;
          wait_nxt           = '0;
          out_data_nxt.phase = phase_r + 1'b1;
        end
      end else begin
        // show the move; advance only if the actuator takes it
        out_data_nxt.cmd_valid = 1'b1;
        out_data_nxt.cmd_kind  = kind_xy;
        out_data_nxt.target_x  = tx;
        out_data_nxt.target_y  = ty;
        out_data_nxt.target_z  = tz;
        if (!in_data.cmd_accepted) begin
          out_data_nxt.verdict    = ppms_pkg::VERDICT_ERROR;
          out_data_nxt.error_code = ppms_pkg::ERR_REFUSED;
        end else begin
          phase_nxt          = phase_r + 1'b1;
          wait_nxt           = '0;
          out_data_nxt.phase = phase_r + 1'b1;
        end
      end
    end
  end

  // Advance state and set valid on an accepted word; clear valid once drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ppms_pkg::PH_RAISE_START;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        wait_r      <= wait_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
